@@ design/ima_adpcm_nibble_decoder_defines.svh @@
// assertion macros for the ima adpcm nibble decoder
// no dependencies; included by the module that carries assertions
`ifndef IMA_ADPCM_NIBBLE_DECODER_DEFINES_SVH
`define IMA_ADPCM_NIBBLE_DECODER_DEFINES_SVH

`ifndef SYNTH
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ design/imad_pkg.sv @@
// shared types, constants and tables for the ima adpcm nibble decoder
// no dependencies
package imad_pkg;

    localparam int unsigned IdxW  = 7;
    localparam int unsigned StepW = 15;
    localparam int unsigned SmpW  = 16;

    localparam logic [IdxW-1:0] IdxMax = 7'd88;
    localparam logic signed [SmpW-1:0] PredMax = 16'sh7fff;
    localparam logic signed [SmpW-1:0] PredMin = 16'sh8000;

    // decoder state carried from one nibble to the next
    typedef struct packed {
        logic signed [SmpW-1:0] pred;
        logic [IdxW-1:0]        idx;
    } t_dec_state;

    // index adjust by code magnitude
    function automatic logic signed [4:0] idx_adjust(input logic [2:0] mag);
        logic signed [4:0] adj;
        case (mag)
            3'd4:    adj = 5'sd2;
            3'd5:    adj = 5'sd4;
            3'd6:    adj = 5'sd6;
            3'd7:    adj = 5'sd8;
            default: adj = -5'sd1;
        endcase
        return adj;
    endfunction

    // step size table, indexes above 87 all read 32767
    function automatic logic [StepW-1:0] step_of_index(input logic [IdxW-1:0] idx);
        logic [StepW-1:0] s;
        case (idx)
            7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
            7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
            7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
            7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
            7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
            7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
            7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
            7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
            7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
            7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
            7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
            7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
            7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
            7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
            7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
            7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
            7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
            7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
            7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
            7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
            7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
            7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
            7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
            7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
            7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
            7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
            7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
            7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
            7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
            7'd87: s = 15'd29794;
            default: s = 15'd32767;
        endcase
        return s;
    endfunction

endpackage

@@ design/ima_adpcm_nibble_decoder.sv @@
// ima adpcm decoder, one byte of two codes in, two 16-bit samples out
// input accept to the earliest result accept passes the input reg, then the result reg
// throughput: one byte per unstalled cycle; two step units chain the codes combinationally
// reset: synchronous active low; clears predictor, step index and both valid flags
// depends on imad_pkg, imad_nibble and ima_adpcm_nibble_decoder_defines.svh
`include "ima_adpcm_nibble_decoder_defines.svh"
module ima_adpcm_nibble_decoder
    import imad_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [7:0]             i_code_byte,
    input  logic                   i_chunk_end,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic signed [SmpW-1:0] o_sample_first,
    output logic signed [SmpW-1:0] o_sample_second,
    output logic                   o_chunk_last
);

    logic                   r_in_valid;
    logic [7:0]             r_in_code;
    logic                   r_in_chunk;
    logic                   r_out_valid;
    logic signed [SmpW-1:0] r_out_first;
    logic signed [SmpW-1:0] r_out_second;
    logic                   r_out_chunk;
    t_dec_state             r_state;

    t_dec_state             mid_state;
    t_dec_state             n_state;
    logic                   out_free;
    logic                   adv;
    logic                   in_take;

    // high nibble first, low nibble on its result
    imad_nibble u_first (
        .i_code  (r_in_code[7:4]),
        .i_state (r_state),
        .o_state (mid_state)
    );

    imad_nibble u_second (
        .i_code  (r_in_code[3:0]),
        .i_state (mid_state),
        .o_state (n_state)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign adv        = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_code  <= i_code_byte;
            r_in_chunk <= i_chunk_end;
        end
        if (adv) begin
            r_out_first  <= mid_state.pred;
            r_out_second <= n_state.pred;
            r_out_chunk  <= r_in_chunk;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_sample_first  = r_out_first;
    assign o_sample_second = r_out_second;
    assign o_chunk_last    = r_out_chunk;

    `ASSERT_IMPLY(a_idx_range, i_clk, i_rst_n, 1'b1, r_state.idx <= IdxMax)
    `ASSERT_NEXT(a_adv_fills_out, i_clk, i_rst_n, adv, r_out_valid)
    `ASSERT_NEXT(a_state_only_on_adv, i_clk, i_rst_n, !adv && i_rst_n, $stable(r_state))
    `ASSERT_IMPLY(a_stall_when_full, i_clk, i_rst_n, o_in_stall, r_in_valid && r_out_valid)

endmodule

@@ design/imad_nibble.sv @@
// one ima adpcm code step: shift-add difference, saturating predictor, index update
// depends on imad_pkg
module imad_nibble
    import imad_pkg::*;
(
    input  logic [3:0]  i_code,
    input  t_dec_state  i_state,
    output t_dec_state  o_state
);

    logic [IdxW-1:0]         idx_c;
    logic [StepW-1:0]        step;
    logic [StepW+1:0]        diff;
    logic signed [SmpW+1:0]  pred_ext;
    logic signed [SmpW+1:0]  diff_s;
    logic signed [SmpW+1:0]  sum;
    logic signed [IdxW+1:0]  ni;

    always_comb begin
        idx_c = (i_state.idx > IdxMax) ? IdxMax : i_state.idx;
        step  = step_of_index(idx_c);

        diff = {2'b00, step >> 3};
        if (i_code[2]) begin
            diff = diff + {2'b00, step};
        end
        if (i_code[1]) begin
            diff = diff + {2'b00, step >> 1};
        end
        if (i_code[0]) begin
            diff = diff + {2'b00, step >> 2};
        end

        pred_ext = {{2{i_state.pred[SmpW-1]}}, i_state.pred};
        diff_s   = signed'({1'b0, diff});
        sum      = i_code[3] ? (pred_ext - diff_s) : (pred_ext + diff_s);

        if (sum > (SmpW+2)'(PredMax)) begin
            o_state.pred = PredMax;
        end else if (sum < (SmpW+2)'(PredMin)) begin
            o_state.pred = PredMin;
        end else begin
            o_state.pred = sum[SmpW-1:0];
        end

        ni = signed'({2'b00, idx_c}) + (IdxW+2)'(idx_adjust(i_code[2:0]));
        if (ni < 0) begin
            o_state.idx = '0;
        end else if (ni > signed'({2'b00, IdxMax})) begin
            o_state.idx = IdxMax;
        end else begin
            o_state.idx = ni[IdxW-1:0];
        end
    end

endmodule
